// ===== design/tbgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbgc_pkg
// Shared types and constants of the touch and button gesture classifier.
// ----------------------------------------------------------------------------
package tbgc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  localparam int RAW_W      = 16;
  localparam int SWIPE_W    = 12;
  localparam int MS_W       = 16;
  localparam int SCREEN_W   = 13;
  localparam int KIND_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SWIPE_W-1:0]  SWIPE_THR_RST  = 12'd52;
  localparam logic [MS_W-1:0]     LONG_PRESS_RST = 16'd650;
  localparam logic [MS_W-1:0]     BTN_LONG_RST   = 16'd900;
  localparam logic [SCREEN_W-1:0] SCREEN_W_RST   = 13'd368;
  localparam logic [SCREEN_W-1:0] SCREEN_H_RST   = 13'd448;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE      = 4'd0,
    EV_TAP       = 4'd1,
    EV_LONG      = 4'd2,
    EV_UP        = 4'd3,
    EV_DOWN      = 4'd4,
    EV_LEFT      = 4'd5,
    EV_RIGHT     = 4'd6,
    EV_BTN_SHORT = 4'd7,
    EV_BTN_LONG  = 4'd8
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWIPE_THR  = 3'd0,
    CFG_LONG_PRESS = 3'd1,
    CFG_BTN_LONG   = 3'd2,
    CFG_SCREEN_W   = 3'd3,
    CFG_SCREEN_H   = 3'd4,
    CFG_ACTIVE_LOW = 3'd5,
    CFG_TOUCH_EN   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SWIPE_W-1:0]  swipe_thr;
    logic [MS_W-1:0]     long_press_ms;
    logic [MS_W-1:0]     button_long_ms;
    logic [SCREEN_W-1:0] screen_w;
    logic [SCREEN_W-1:0] screen_h;
    logic                active_low;
    logic                touch_en;
  } cfg_t;

  typedef struct packed {
    logic        fire;
    event_kind_e kind;
  } btn_evt_t;

endpackage

// ===== design/tbgc_cfg.sv =====
// ----------------------------------------------------------------------------
// tbgc_cfg
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module tbgc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [tbgc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbgc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tbgc_pkg::cfg_t                  cfg_o
);

  tbgc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tbgc_pkg::cfg_idx_e'(cfg_index_i))
        tbgc_pkg::CFG_SWIPE_THR:  cfg_d.swipe_thr      = cfg_data_i[tbgc_pkg::SWIPE_W-1:0];
        tbgc_pkg::CFG_LONG_PRESS: cfg_d.long_press_ms  = cfg_data_i[tbgc_pkg::MS_W-1:0];
        tbgc_pkg::CFG_BTN_LONG:   cfg_d.button_long_ms = cfg_data_i[tbgc_pkg::MS_W-1:0];
        tbgc_pkg::CFG_SCREEN_W:   cfg_d.screen_w       = cfg_data_i[tbgc_pkg::SCREEN_W-1:0];
        tbgc_pkg::CFG_SCREEN_H:   cfg_d.screen_h       = cfg_data_i[tbgc_pkg::SCREEN_W-1:0];
        tbgc_pkg::CFG_ACTIVE_LOW: cfg_d.active_low     = cfg_data_i[0];
        tbgc_pkg::CFG_TOUCH_EN:   cfg_d.touch_en       = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swipe_thr      <= tbgc_pkg::SWIPE_THR_RST;
      cfg_q.long_press_ms  <= tbgc_pkg::LONG_PRESS_RST;
      cfg_q.button_long_ms <= tbgc_pkg::BTN_LONG_RST;
      cfg_q.screen_w       <= tbgc_pkg::SCREEN_W_RST;
      cfg_q.screen_h       <= tbgc_pkg::SCREEN_H_RST;
      cfg_q.active_low     <= 1'b1;
      cfg_q.touch_en       <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/tbgc_button.sv =====
// ----------------------------------------------------------------------------
// tbgc_button
// Button press tracking: long event while held, short event on early release.
// ----------------------------------------------------------------------------
module tbgc_button #(
  parameter int TIME_BITS = tbgc_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         level_i,
  input  logic [TIME_BITS-1:0]         now_i,
  input  tbgc_pkg::cfg_t               cfg_i,
  output tbgc_pkg::btn_evt_t           evt_o,
  output logic [TIME_BITS-1:0]         dur_o
);

  logic                 held_q, held_d;
  logic                 lrep_q, lrep_d;
  logic [TIME_BITS-1:0] begin_q, begin_d;
  logic                 pressed;
  logic [TIME_BITS-1:0] held_time;

  assign pressed   = cfg_i.active_low ? !level_i : level_i;
  assign held_time = now_i - begin_q;

  always_comb begin
    held_d     = held_q;
    lrep_d     = lrep_q;
    begin_d    = begin_q;
    evt_o.fire = 1'b0;
    evt_o.kind = tbgc_pkg::EV_NONE;
    dur_o      = held_time;
    priority if (pressed && !held_q) begin
      held_d  = 1'b1;
      lrep_d  = 1'b0;
      begin_d = now_i;
    end else if (pressed && !lrep_q) begin
      if (held_time >= TIME_BITS'(cfg_i.button_long_ms)) begin
        lrep_d     = 1'b1;
        evt_o.fire = 1'b1;
        evt_o.kind = tbgc_pkg::EV_BTN_LONG;
      end
    end else if (!pressed && held_q) begin
      held_d = 1'b0;
      if (!lrep_q) begin
        evt_o.fire = 1'b1;
        evt_o.kind = tbgc_pkg::EV_BTN_SHORT;
      end
    end else begin
      // held after the long event, or released and idle
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      lrep_q  <= 1'b0;
      begin_q <= '0;
    end else if (step_i) begin
      held_q  <= held_d;
      lrep_q  <= lrep_d;
      begin_q <= begin_d;
    end
  end

endmodule

// ===== design/tbgc_touch.sv =====
// ----------------------------------------------------------------------------
// tbgc_touch
// Touch tracking: coordinate clamp, contact capture and release gesture decode.
// ----------------------------------------------------------------------------
module tbgc_touch #(
  parameter int COORD_BITS = tbgc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tbgc_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             sample_i,
  input  logic                             down_i,
  input  logic signed [tbgc_pkg::RAW_W-1:0] raw_x_i,
  input  logic signed [tbgc_pkg::RAW_W-1:0] raw_y_i,
  input  logic [TIME_BITS-1:0]             now_i,
  input  tbgc_pkg::cfg_t                   cfg_i,
  output tbgc_pkg::event_kind_e            kind_o,
  output logic [COORD_BITS-1:0]            end_x_o,
  output logic [COORD_BITS-1:0]            end_y_o,
  output logic [COORD_BITS-1:0]            begin_x_o,
  output logic [COORD_BITS-1:0]            begin_y_o,
  output logic [TIME_BITS-1:0]             dur_o
);

  localparam int CW = 17;
  localparam logic [CW-1:0] COORD_MAX = CW'((64'd1 << COORD_BITS) - 64'd1);

  function automatic logic [COORD_BITS-1:0] clamp(
    input logic [tbgc_pkg::RAW_W-1:0]  raw,
    input logic [tbgc_pkg::SCREEN_W-1:0] size
  );
    logic [CW-1:0] lim;
    logic [CW-1:0] v;
    lim = (size == '0) ? '0 : CW'(size - 1'b1);
    if (lim > COORD_MAX) lim = COORD_MAX;
    v = CW'(raw[tbgc_pkg::RAW_W-2:0]);
    if (raw[tbgc_pkg::RAW_W-1]) clamp = '0;
    else if (v > lim)           clamp = COORD_BITS'(lim);
    else                        clamp = COORD_BITS'(v);
  endfunction

  logic                  held_q, held_d;
  logic [COORD_BITS-1:0] fx_q, fx_d, fy_q, fy_d, lx_q, lx_d, ly_q, ly_d;
  logic [TIME_BITS-1:0]  tb_q, tb_d;

  logic [COORD_BITS-1:0] x, y;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0] ax, ay;
  logic                  swipe;
  logic [TIME_BITS-1:0]  dur;
  tbgc_pkg::event_kind_e gest;

  assign x   = clamp(raw_x_i, cfg_i.screen_w);
  assign y   = clamp(raw_y_i, cfg_i.screen_h);
  assign dx  = $signed({1'b0, lx_q}) - $signed({1'b0, fx_q});
  assign dy  = $signed({1'b0, ly_q}) - $signed({1'b0, fy_q});
  assign ax  = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign ay  = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  assign dur = now_i - tb_q;
  assign swipe = (CW'(ax) > CW'(cfg_i.swipe_thr)) || (CW'(ay) > CW'(cfg_i.swipe_thr));

  always_comb begin
    priority if (swipe) begin
      if (ax > ay) begin
        gest = dx[COORD_BITS] ? tbgc_pkg::EV_LEFT : tbgc_pkg::EV_RIGHT;
      end else begin
        gest = (!dy[COORD_BITS] && dy != '0) ? tbgc_pkg::EV_DOWN : tbgc_pkg::EV_UP;
      end
    end else if (dur >= TIME_BITS'(cfg_i.long_press_ms)) begin
      gest = tbgc_pkg::EV_LONG;
    end else begin
      gest = tbgc_pkg::EV_TAP;
    end
  end

  always_comb begin
    held_d    = held_q;
    fx_d      = fx_q;
    fy_d      = fy_q;
    lx_d      = lx_q;
    ly_d      = ly_q;
    tb_d      = tb_q;
    kind_o    = tbgc_pkg::EV_NONE;
    end_x_o   = '0;
    end_y_o   = '0;
    begin_x_o = '0;
    begin_y_o = '0;
    dur_o     = '0;
    if (sample_i) begin
      priority if (down_i) begin
        if (!held_q) begin
          held_d = 1'b1;
          fx_d   = x;
          fy_d   = y;
          tb_d   = now_i;
        end
        lx_d = x;
        ly_d = y;
      end else if (held_q) begin
        held_d    = 1'b0;
        kind_o    = gest;
        end_x_o   = lx_q;
        end_y_o   = ly_q;
        begin_x_o = fx_q;
        begin_y_o = fy_q;
        dur_o     = dur;
      end else begin
        // no contact and none pending
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      fx_q   <= '0;
      fy_q   <= '0;
      lx_q   <= '0;
      ly_q   <= '0;
      tb_q   <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      fx_q   <= fx_d;
      fy_q   <= fy_d;
      lx_q   <= lx_d;
      ly_q   <= ly_d;
      tb_q   <= tb_d;
    end
  end

endmodule

// ===== design/touch_button_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// touch_button_gesture_classifier
// Classifies polled button and touch samples into tap, long press, swipe and
// button short/long events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one poll sample per beat.
//   Every sample gives exactly one result beat on the output channel
//   (out_valid_o/out_ready_i); event_kind_o is zero when nothing happened.
//   Config channel (cfg_valid_i/cfg_ready_o) writes one register per beat,
//   always ready; write only while no sample is in flight.
//   A sample accepted on the input channel is registered, evaluated and
//   moved into the output register once that register is free or taken.
//   One sample per cycle while the output is not stalled, with the evaluation
//   between the input register and the output register combinational.
//   Reset clears tracking state and loads the default register values.
//   A stalled receiver holds the output register; the input register fills,
//   then in_ready_o drops until the output beat is taken.
// ----------------------------------------------------------------------------
module touch_button_gesture_classifier #(
  parameter int COORD_BITS = tbgc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tbgc_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbgc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbgc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              button_level_i,
  input  logic                              touch_down_i,
  input  logic signed [tbgc_pkg::RAW_W-1:0] touch_raw_x_i,
  input  logic signed [tbgc_pkg::RAW_W-1:0] touch_raw_y_i,
  input  logic [TIME_BITS-1:0]              now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tbgc_pkg::KIND_W-1:0]       event_kind_o,
  output logic [COORD_BITS-1:0]             end_x_o,
  output logic [COORD_BITS-1:0]             end_y_o,
  output logic [COORD_BITS-1:0]             begin_x_o,
  output logic [COORD_BITS-1:0]             begin_y_o,
  output logic [TIME_BITS-1:0]              duration_ms_o
);

  tbgc_pkg::cfg_t cfg;

  logic                              s1_valid_q;
  logic                              lvl_q, down_q;
  logic signed [tbgc_pkg::RAW_W-1:0] rx_q, ry_q;
  logic [TIME_BITS-1:0]              now_q;
  logic                              advance;

  tbgc_pkg::btn_evt_t    btn_evt;
  logic [TIME_BITS-1:0]  btn_dur;
  tbgc_pkg::event_kind_e t_kind;
  logic [COORD_BITS-1:0] t_ex, t_ey, t_bx, t_by;
  logic [TIME_BITS-1:0]  t_dur;

  logic                  out_valid_q;
  tbgc_pkg::event_kind_e kind_q, kind_d;
  logic [COORD_BITS-1:0] ex_q, ex_d, ey_q, ey_d, bx_q, bx_d, by_q, by_d;
  logic [TIME_BITS-1:0]  dur_q, dur_d;

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;

  tbgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      lvl_q  <= button_level_i;
      down_q <= touch_down_i;
      rx_q   <= touch_raw_x_i;
      ry_q   <= touch_raw_y_i;
      now_q  <= now_ms_i;
    end
  end

  tbgc_button #(.TIME_BITS(TIME_BITS)) u_button (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (lvl_q),
    .now_i   (now_q),
    .cfg_i   (cfg),
    .evt_o   (btn_evt),
    .dur_o   (btn_dur)
  );

  tbgc_touch #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_touch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .sample_i  (!btn_evt.fire),
    .down_i    (down_q && cfg.touch_en),
    .raw_x_i   (rx_q),
    .raw_y_i   (ry_q),
    .now_i     (now_q),
    .cfg_i     (cfg),
    .kind_o    (t_kind),
    .end_x_o   (t_ex),
    .end_y_o   (t_ey),
    .begin_x_o (t_bx),
    .begin_y_o (t_by),
    .dur_o     (t_dur)
  );

  always_comb begin
    if (btn_evt.fire) begin
      kind_d = btn_evt.kind;
      ex_d   = '0;
      ey_d   = '0;
      bx_d   = '0;
      by_d   = '0;
      dur_d  = btn_dur;
    end else begin
      kind_d = t_kind;
      ex_d   = t_ex;
      ey_d   = t_ey;
      bx_d   = t_bx;
      by_d   = t_by;
      dur_d  = t_dur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= kind_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      dur_q  <= dur_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign end_x_o       = ex_q;
  assign end_y_o       = ey_q;
  assign begin_x_o     = bx_q;
  assign begin_y_o     = by_q;
  assign duration_ms_o = dur_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are full and stalled");

  a_button_no_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == tbgc_pkg::EV_BTN_SHORT || kind_q == tbgc_pkg::EV_BTN_LONG))
    |-> (ex_q == '0 && ey_q == '0 && bx_q == '0 && by_q == '0))
    else $error("button beat carries touch coordinates");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == tbgc_pkg::EV_NONE) |-> (dur_q == '0 && ex_q == '0))
    else $error("empty beat carries nonzero payload");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated sample did not reach the output register");

endmodule

// ===== bench/gesture_event_checker.sv =====
// ----------------------------------------------------------------------------
// gesture_event_checker
// Watches the config, sample and event channels of the gesture classifier.
// Keeps its own copy of the registers and the button and touch tracking
// state, works out the event for every accepted sample, and compares each
// event beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gesture_event_checker
  import tbgc_pkg::*;
#(
  parameter int COORD_W = COORD_BITS_DEF,
  parameter int TIME_W  = TIME_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    button_level_i,
  input  logic                    touch_down_i,
  input  logic signed [RAW_W-1:0] touch_raw_x_i,
  input  logic signed [RAW_W-1:0] touch_raw_y_i,
  input  logic [TIME_W-1:0]       now_ms_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [KIND_W-1:0]       event_kind_i,
  input  logic [COORD_W-1:0]      end_x_i,
  input  logic [COORD_W-1:0]      end_y_i,
  input  logic [COORD_W-1:0]      begin_x_i,
  input  logic [COORD_W-1:0]      begin_y_i,
  input  logic [TIME_W-1:0]       duration_ms_i,
  output int unsigned             pending_o,
  output int unsigned             fails_o
);

  typedef struct packed {
    event_kind_e        kind;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] begin_x;
    logic [COORD_W-1:0] begin_y;
    logic [TIME_W-1:0]  duration;
  } gesture_evt_t;

  gesture_evt_t       event_q[$];
  int unsigned        fail_count;
  cfg_t               regs;

  logic               touch_held;
  logic [COORD_W-1:0] first_x;
  logic [COORD_W-1:0] first_y;
  logic [COORD_W-1:0] latest_x;
  logic [COORD_W-1:0] latest_y;
  logic [TIME_W-1:0]  touch_t0;
  logic               button_held;
  logic               long_sent;
  logic [TIME_W-1:0]  button_t0;

  function automatic logic [COORD_W-1:0] clamp_axis(logic signed [RAW_W-1:0] raw,
                                                    logic [SCREEN_W-1:0] size);
    int v;
    int lim;
    v   = raw;
    lim = (size == '0) ? 0 : int'(size) - 1;
    if (lim > (1 << COORD_W) - 1) lim = (1 << COORD_W) - 1;
    if (v < 0) return '0;
    if (v > lim) return lim[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_SWIPE_THR:  regs.swipe_thr      = data[SWIPE_W-1:0];
      CFG_LONG_PRESS: regs.long_press_ms  = data[MS_W-1:0];
      CFG_BTN_LONG:   regs.button_long_ms = data[MS_W-1:0];
      CFG_SCREEN_W:   regs.screen_w       = data[SCREEN_W-1:0];
      CFG_SCREEN_H:   regs.screen_h       = data[SCREEN_W-1:0];
      CFG_ACTIVE_LOW: regs.active_low     = data[0];
      CFG_TOUCH_EN:   regs.touch_en       = data[0];
      default: ;
    endcase
  endtask

  task automatic classify_sample(input logic lvl, input logic dn,
                                 input logic signed [RAW_W-1:0] rx,
                                 input logic signed [RAW_W-1:0] ry,
                                 input logic [TIME_W-1:0] now);
    gesture_evt_t       ev;
    logic               pressed;
    logic               down;
    logic               btn_fired;
    logic [TIME_W-1:0]  held;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    int                 dx;
    int                 dy;
    int                 ax;
    int                 ay;
    ev        = '0;
    ev.kind   = EV_NONE;
    btn_fired = 1'b0;
    pressed   = regs.active_low ? !lvl : lvl;
    down      = regs.touch_en && dn;

    if (pressed && !button_held) begin
      button_held = 1'b1;
      long_sent   = 1'b0;
      button_t0   = now;
    end else if (pressed && button_held && !long_sent) begin
      held = now - button_t0;
      if (held >= TIME_W'(regs.button_long_ms)) begin
        long_sent   = 1'b1;
        ev.kind     = EV_BTN_LONG;
        ev.duration = held;
        btn_fired   = 1'b1;
      end
    end else if (!pressed && button_held) begin
      button_held = 1'b0;
      if (!long_sent) begin
        ev.kind     = EV_BTN_SHORT;
        ev.duration = now - button_t0;
        btn_fired   = 1'b1;
      end
    end

    // a button event masks the touch for this sample
    if (!btn_fired) begin
      if (down) begin
        px = clamp_axis(rx, regs.screen_w);
        py = clamp_axis(ry, regs.screen_h);
        if (!touch_held) begin
          touch_held = 1'b1;
          first_x    = px;
          first_y    = py;
          touch_t0   = now;
        end
        latest_x = px;
        latest_y = py;
      end else if (touch_held) begin
        touch_held  = 1'b0;
        dx          = int'(latest_x) - int'(first_x);
        dy          = int'(latest_y) - int'(first_y);
        ax          = (dx < 0) ? -dx : dx;
        ay          = (dy < 0) ? -dy : dy;
        ev.duration = now - touch_t0;
        if (ax > int'(regs.swipe_thr) || ay > int'(regs.swipe_thr)) begin
          // ties go vertical
          if (ax > ay) ev.kind = (dx > 0) ? EV_RIGHT : EV_LEFT;
          else ev.kind = (dy > 0) ? EV_DOWN : EV_UP;
        end else if (ev.duration >= TIME_W'(regs.long_press_ms)) begin
          ev.kind = EV_LONG;
        end else begin
          ev.kind = EV_TAP;
        end
        ev.end_x   = latest_x;
        ev.end_y   = latest_y;
        ev.begin_x = first_x;
        ev.begin_y = first_y;
      end
    end
    event_q.push_back(ev);
  endtask

  task automatic check_event();
    gesture_evt_t want;
    if (event_q.size() == 0) begin
      $error("event beat with no sample outstanding, kind %0d", event_kind_i);
      fail_count++;
    end else begin
      want = event_q.pop_front();
      check_field("event_kind", want.kind, event_kind_i);
      check_field("end_x", want.end_x, end_x_i);
      check_field("end_y", want.end_y, end_y_i);
      check_field("begin_x", want.begin_x, begin_x_i);
      check_field("begin_y", want.begin_y, begin_y_i);
      check_field("duration_ms", want.duration, duration_ms_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.swipe_thr      = SWIPE_THR_RST;
      regs.long_press_ms  = LONG_PRESS_RST;
      regs.button_long_ms = BTN_LONG_RST;
      regs.screen_w       = SCREEN_W_RST;
      regs.screen_h       = SCREEN_H_RST;
      regs.active_low     = 1'b1;
      regs.touch_en       = 1'b1;
      touch_held          = 1'b0;
      first_x             = '0;
      first_y             = '0;
      latest_x            = '0;
      latest_y            = '0;
      touch_t0            = '0;
      button_held         = 1'b0;
      long_sent           = 1'b0;
      button_t0           = '0;
      fail_count          = 0;
      event_q.delete();
    end else begin
      // retire before predicting: an event never belongs to the same-edge sample
      if (out_valid_i && out_ready_i) check_event();
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        classify_sample(button_level_i, touch_down_i, touch_raw_x_i, touch_raw_y_i, now_ms_i);
      end
    end
    pending_o <= event_q.size();
    fails_o   <= fail_count;
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the touch and button gesture classifier: a directed pass over
// taps, long presses, swipes, button events and time wrap, then phases of
// random button and touch gestures under changing register settings, with
// random idle bursts on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import tbgc_pkg::*;

  localparam int COORD_W        = COORD_BITS_DEF;
  localparam int TIME_W         = TIME_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    button_level_i;
  logic                    touch_down_i;
  logic signed [RAW_W-1:0] touch_raw_x_i;
  logic signed [RAW_W-1:0] touch_raw_y_i;
  logic [TIME_W-1:0]       now_ms_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b1;
  logic [KIND_W-1:0]       event_kind_o;
  logic [COORD_W-1:0]      end_x_o;
  logic [COORD_W-1:0]      end_y_o;
  logic [COORD_W-1:0]      begin_x_o;
  logic [COORD_W-1:0]      begin_y_o;
  logic [TIME_W-1:0]       duration_ms_o;

  int unsigned pending;
  int unsigned fails;
  int          idle_pct   = 0;
  bit          quiet      = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          sent       = 0;
  logic [31:0] clock_ms;
  int          sh_thr;
  int          sh_lp;
  int          sh_bl;
  int          sh_sw;
  bit          sh_al;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  touch_button_gesture_classifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .button_level_i(button_level_i),
    .touch_down_i  (touch_down_i),
    .touch_raw_x_i (touch_raw_x_i),
    .touch_raw_y_i (touch_raw_y_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .end_x_o       (end_x_o),
    .end_y_o       (end_y_o),
    .begin_x_o     (begin_x_o),
    .begin_y_o     (begin_y_o),
    .duration_ms_o (duration_ms_o)
  );

  gesture_event_checker event_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .button_level_i(button_level_i),
    .touch_down_i  (touch_down_i),
    .touch_raw_x_i (touch_raw_x_i),
    .touch_raw_y_i (touch_raw_y_i),
    .now_ms_i      (now_ms_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_i  (event_kind_o),
    .end_x_i       (end_x_o),
    .end_y_i       (end_y_o),
    .begin_x_i     (begin_x_o),
    .begin_y_i     (begin_y_o),
    .duration_ms_i (duration_ms_o),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  // event-side backpressure
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && idle_pct != 0 && stall_left == 0 &&
                 $urandom_range(0, 99) < idle_pct) begin
      stall_left  <= $urandom_range(1, 5);
      out_ready_i <= 1'b0;
    end else begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[touch_button_gesture_classifier] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic lvl, input logic dn, input int rx, input int ry,
                             input logic [31:0] ms);
    if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= lvl;
    touch_down_i   <= dn;
    touch_raw_x_i  <= rx[15:0];
    touch_raw_y_i  <= ry[15:0];
    now_ms_i       <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SWIPE_THR:  sh_thr = value;
      CFG_LONG_PRESS: sh_lp  = value;
      CFG_BTN_LONG:   sh_bl  = value;
      CFG_SCREEN_W:   sh_sw  = value;
      CFG_ACTIVE_LOW: sh_al  = value[0];
      default: ;
    endcase
  endtask

  // One gesture: a button hold and/or a touch stroke over a few samples,
  // or now and then a single sample of pure noise.
  task automatic run_episode();
    int          n;
    int          bs;
    int          be;
    int          ts;
    int          te;
    int          i;
    int          span;
    int          travel;
    int          tx;
    int          ty;
    int          sx;
    int          sy;
    int          ex;
    int          ey;
    int          x;
    int          y;
    bit          btn_use;
    bit          touch_use;
    bit          pressed;
    bit          dn;
    logic [31:0] t;
    logic [31:0] bt0;
    logic [31:0] tt0;
    if ($urandom_range(0, 9) == 0) begin
      send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
    end else begin
      n         = $urandom_range(2, 8);
      btn_use   = $urandom_range(0, 99) < 45;
      touch_use = !btn_use || ($urandom_range(0, 1) == 1);
      bs        = $urandom_range(0, n - 2);
      be        = $urandom_range(bs + 1, n - 1);
      ts        = $urandom_range(0, n - 2);
      te        = $urandom_range(ts + 1, n - 1);
      span      = ((sh_lp > sh_bl) ? sh_lp : sh_bl) * 2 / (n - 1) + 4;
      travel    = ($urandom_range(0, 1) == 1) ? sh_thr + int'($urandom_range(0, 2)) - 1
                                              : int'($urandom_range(0, 2 * sh_thr + 10));
      tx        = travel;
      ty        = ($urandom_range(0, 4) == 0) ? travel
                                              : int'($urandom_range(0, 2 * sh_thr + 10));
      if ($urandom_range(0, 1) == 1) begin
        tx = ty;
        ty = travel;
      end
      sx = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, sh_sw));
      sy = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                       : int'($urandom_range(0, 4200));
      ex = ($urandom_range(0, 1) == 1) ? sx + tx : sx - tx;
      ey = ($urandom_range(0, 1) == 1) ? sy + ty : sy - ty;
      case ($urandom_range(0, 19))
        0:       t = $urandom();
        1:       t = 32'hFFFF_FFFF - $urandom_range(0, span);
        default: t = clock_ms;
      endcase
      bt0 = t;
      tt0 = t;
      for (i = 0; i < n; i++) begin
        if (i > 0) begin
          t = t + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(0, span));
        end
        pressed = btn_use && i >= bs && i < be;
        dn      = touch_use && i >= ts && i < te;
        if (i == bs) bt0 = t;
        if (i == ts) tt0 = t;
        // land on the hold limits now and then
        if (btn_use && i > bs && i <= be && $urandom_range(0, 3) == 0) begin
          t = bt0 + sh_bl - $urandom_range(0, 1);
        end else if (touch_use && i == te && $urandom_range(0, 2) == 0) begin
          t = tt0 + sh_lp - $urandom_range(0, 1);
        end
        if (!dn || $urandom_range(0, 9) == 0) begin
          x = $urandom_range(0, 65535);
          y = $urandom_range(0, 65535);
        end else if (i == ts) begin
          x = sx;
          y = sy;
        end else if (i == te - 1) begin
          x = ex;
          y = ey;
        end else begin
          x = sx + int'($urandom_range(0, 20)) - 10;
          y = sy + int'($urandom_range(0, 20)) - 10;
        end
        send_sample(sh_al ? !pressed : pressed, dn, x, y, t);
      end
      clock_ms = t + $urandom_range(0, span);
    end
  endtask

  task automatic run_phase(input int thr, input int lp, input int bl, input int sw,
                           input int sh, input int al, input int te, input int items,
                           input int idle);
    int stop;
    drain();
    write_reg(CFG_SWIPE_THR, thr);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_BTN_LONG, bl);
    write_reg(CFG_SCREEN_W, sw);
    write_reg(CFG_SCREEN_H, sh);
    write_reg(CFG_ACTIVE_LOW, al);
    write_reg(CFG_TOUCH_EN, te);
    cfg_valid_i <= 1'b0;
    idle_pct = idle;
    stop     = sent + items;
    while (sent < stop) run_episode();
  endtask

  initial begin
    int p;
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_SWIPE_THR;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    button_level_i <= 1'b1;
    touch_down_i   <= 1'b0;
    touch_raw_x_i  <= '0;
    touch_raw_y_i  <= '0;
    now_ms_i       <= '0;
    sh_thr   = SWIPE_THR_RST;
    sh_lp    = LONG_PRESS_RST;
    sh_bl    = BTN_LONG_RST;
    sh_sw    = SCREEN_W_RST;
    sh_al    = 1'b1;
    clock_ms = 32'd20000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 20;

    // directed pass under reset settings
    send_sample(1, 0, 0, 0, 0);
    send_sample(1, 1, -32768, -32768, 100);
    send_sample(1, 1, 32767, 32767, 150);
    send_sample(1, 0, 0, 0, 400);
    send_sample(1, 1, 100, 100, 1000);
    send_sample(1, 0, 5, 5, 1649);
    send_sample(1, 1, 100, 100, 2000);
    send_sample(1, 0, 0, 0, 2650);
    send_sample(1, 1, 200, 200, 3000);
    send_sample(1, 1, 147, 200, 3010);
    send_sample(1, 0, 0, 0, 3020);
    send_sample(1, 1, 100, 300, 4000);
    send_sample(1, 1, 160, 240, 4010);
    send_sample(1, 0, 0, 0, 4020);
    send_sample(1, 1, 10, 10, 4100);
    send_sample(1, 1, 63, 10, 4110);
    send_sample(1, 0, 0, 0, 4120);
    send_sample(0, 0, 0, 0, 5000);
    send_sample(0, 0, 0, 0, 5899);
    send_sample(0, 0, 0, 0, 5900);
    send_sample(1, 0, 0, 0, 6000);
    send_sample(0, 1, 30, 40, 7000);
    send_sample(1, 0, 0, 0, 7100);
    send_sample(1, 0, 0, 0, 7200);
    send_sample(1, 1, 5, 5, 32'hFFFF_FFF0);
    send_sample(1, 0, 0, 0, 32'h0000_0010);

    run_phase(0, 0, 0, 1, 1, 0, 1, 200, 30);
    run_phase(4095, 65535, 65535, 4096, 4096, 1, 1, 200, 0);
    run_phase(52, 650, 900, 368, 448, 1, 0, 150, 20);
    run_phase(20, 100, 150, 0, 8191, 0, 1, 200, 25);
    for (p = 0; p < 4; p++) begin
      run_phase($urandom_range(0, 200), $urandom_range(0, 3000), $urandom_range(0, 3000),
                $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 1),
                int'($urandom_range(0, 5) != 0), 250, (p % 2 == 0) ? 35 : 0);
    end
    quiet = 1'b1;
    run_phase(SWIPE_THR_RST, LONG_PRESS_RST, BTN_LONG_RST, SCREEN_W_RST, SCREEN_H_RST, 1, 1,
              200, 0);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("[touch_button_gesture_classifier] OK");
    end else begin
      $display("[touch_button_gesture_classifier] ERROR");
    end
    $finish;
  end

endmodule
